// File: hw/rtl/mtws_pkg.sv
// Package for the multi-task watchdog supervisor.
// Holds sizes, opcodes and the structs shared by the cell chain and the top level.
// No dependencies.
package mtws_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = 6;
    localparam int FROZEN_W  = 7;
    localparam int TMO_W     = 16;
    localparam int STEP_W    = 8;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 8'd10;
    localparam logic [TMO_W-1:0]  ELAPSED_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_CHECKIN  = 2'd1,
        FUNC_TICK     = 2'd2
    } func_t;

    typedef enum logic {
        S_IDLE,
        S_TICK
    } state_t;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic             wr_en;
        logic             chk_en;
        logic [ID_W-1:0]  idx;
        logic [TMO_W-1:0] timeout;
        logic             init_flag;
    } cell_cmd_t;

    // Tick token and running tallies handed from cell to cell.
    typedef struct packed {
        logic                token;
        logic [FROZEN_W-1:0] frozen;
        logic [ID_W-1:0]     first;
    } chain_t;

    typedef struct packed {
        logic [ID_W-1:0]     assigned_id;
        logic                table_full;
        logic                bad_id;
        logic                feed_watchdog;
        logic [FROZEN_W-1:0] frozen_count;
        logic [ID_W-1:0]     first_frozen;
    } result_t;

endpackage

// File: hw/rtl/mtws_cell.sv
// One task slot of the supervisor chain: timeout, check-in flag and elapsed time.
// Depends on mtws_pkg.
module mtws_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mtws_pkg::STEP_W-1:0]   tick_step,
    input  logic [mtws_pkg::ID_W-1:0]     cell_id,
    input  mtws_pkg::cell_cmd_t           cmd,
    input  mtws_pkg::chain_t              chain_in,
    output mtws_pkg::chain_t              chain_out
);
    import mtws_pkg::*;

    logic             active_reg;
    logic             flag_reg;
    logic             flag_next;
    logic [TMO_W-1:0] elapsed_reg;
    logic [TMO_W-1:0] elapsed_next;
    logic [TMO_W-1:0] timeout_reg;
    logic [TMO_W:0]   sum;
    logic             hit;
    logic             frozen;
    chain_t           chain_reg;
    chain_t           chain_next;

    assign hit = (cmd.idx == cell_id);
    assign sum = {1'b0, elapsed_reg} + {{(TMO_W + 1 - STEP_W){1'b0}}, tick_step};

    always_comb
    begin
        flag_next    = flag_reg;
        elapsed_next = elapsed_reg;
        frozen       = 1'b0;
        chain_next   = chain_in;
        if (chain_in.token && active_reg)
        begin
            if (flag_reg)
            begin
                flag_next    = 1'b0;
                elapsed_next = '0;
            end
            else if (sum[TMO_W])
            begin
                elapsed_next = ELAPSED_MAX;
            end
            else
            begin
                elapsed_next = sum[TMO_W-1:0];
            end
            frozen = (elapsed_next >= timeout_reg);
            if (frozen)
            begin
                chain_next.frozen = chain_in.frozen + FROZEN_W'(1);
                if (chain_in.frozen == '0)
                begin
                    chain_next.first = cell_id;
                end
            end
        end
        else if (cmd.wr_en && hit)
        begin
            flag_next    = cmd.init_flag;
            elapsed_next = '0;
        end
        else if (cmd.chk_en && hit)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            flag_reg    <= 1'b0;
            elapsed_reg <= '0;
            chain_reg   <= '0;
        end
        else
        begin
            flag_reg    <= flag_next;
            elapsed_reg <= elapsed_next;
            chain_reg   <= chain_next;
            if (cmd.wr_en && hit)
            begin
                active_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && hit)
        begin
            timeout_reg <= cmd.timeout;
        end
    end

    assign chain_out = chain_reg;

endmodule

// File: hw/rtl/multi_task_watchdog_supervisor_top.sv
// Top level of the multi-task watchdog supervisor.
// Depends on mtws_pkg and mtws_cell.
//
// Usage: items enter on in_valid/in_ready with func, task_id, timeout_ms and
// initially_checked_in; each item yields exactly one result on out_valid/out_ready.
// A register item stores a task in the next free slot and returns its id, or
// sets table_full once MAX_TASKS slots are taken. A check-in item sets the flag
// of a registered task, or sets bad_id. A tick item updates every task.
// Register and check-in items finish in the accept cycle; the result passes
// through the internal result register to the output register.
// A tick sends a token down the chain of MAX_TASKS cells, one cell per cycle;
// when the token leaves the last cell, the result goes through the internal
// result register to the output register.
// The next item is taken only once the previous result has left the internal
// result register, so items are handled one at a time. A stalled receiver keeps
// both registers full and in_ready low.
// The tick step is written on cfg_valid/cfg_ready, which is always ready; write
// it only while the block is idle. Reset empties the table and sets the step
// to 10 ms.
module multi_task_watchdog_supervisor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtws_pkg::STEP_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [mtws_pkg::ID_W-1:0]     task_id,
    input  logic [mtws_pkg::TMO_W-1:0]    timeout_ms,
    input  logic                          initially_checked_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mtws_pkg::ID_W-1:0]     assigned_id,
    output logic                          table_full,
    output logic                          bad_id,
    output logic                          feed_watchdog,
    output logic [mtws_pkg::FROZEN_W-1:0] frozen_count,
    output logic [mtws_pkg::ID_W-1:0]     first_frozen
);
    import mtws_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STEP_W-1:0]   step_reg;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    result_t             pend_reg;
    result_t             pend_next;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                accept;
    logic                out_move;
    logic                start;
    cell_cmd_t           cmd;
    chain_t              chain [MAX_TASKS+1];
    logic [MAX_TASKS-1:0] tokens;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !pend_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_move  = pend_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        chain[0].token  = start;
        chain[0].frozen = '0;
        chain[0].first  = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            mtws_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .tick_step (step_reg),
                .cell_id   (ID_W'(gi)),
                .cmd       (cmd),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1])
            );
            assign tokens[gi] = chain[gi+1].token;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg && !out_move;
        start           = 1'b0;
        cmd             = '0;
        cmd.timeout     = timeout_ms;
        cmd.init_flag   = initially_checked_in;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next       = '0;
                    pend_valid_next = 1'b1;
                    unique case (func)
                        FUNC_REGISTER:
                        begin
                            if (count_reg == CNT_W'(MAX_TASKS))
                            begin
                                pend_next.table_full = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_en             = 1'b1;
                                cmd.idx               = ID_W'(count_reg);
                                pend_next.assigned_id = ID_W'(count_reg);
                                count_next            = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_CHECKIN:
                        begin
                            if ({1'b0, task_id} < FROZEN_W'(count_reg))
                            begin
                                cmd.chk_en = 1'b1;
                                cmd.idx    = task_id;
                            end
                            else
                            begin
                                pend_next.bad_id = 1'b1;
                            end
                        end
                        FUNC_TICK:
                        begin
                            pend_valid_next = 1'b0;
                            start           = 1'b1;
                            state_next      = S_TICK;
                        end
                        default:
                        begin
                            pend_next = '0;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (chain[MAX_TASKS].token)
                begin
                    pend_next               = '0;
                    pend_next.frozen_count  = chain[MAX_TASKS].frozen;
                    pend_next.first_frozen  = chain[MAX_TASKS].first;
                    pend_next.feed_watchdog = (chain[MAX_TASKS].frozen == '0);
                    pend_valid_next         = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            step_reg       <= TICK_STEP_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
            if (out_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (out_move)
        begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign assigned_id   = out_reg.assigned_id;
    assign table_full    = out_reg.table_full;
    assign bad_id        = out_reg.bad_id;
    assign feed_watchdog = out_reg.feed_watchdog;
    assign frozen_count  = out_reg.frozen_count;
    assign first_frozen  = out_reg.first_frozen;

    // Only one tick token may travel the chain at a time.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tokens))
        else $error("more than one tick token in the cell chain");

    // A token can only be in the chain while a tick is being processed.
    a_token_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens != '0) |-> (state_reg == S_TICK))
        else $error("tick token outside a tick");

    // A tick never reports more frozen tasks than are registered.
    a_frozen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain[MAX_TASKS].token |-> (chain[MAX_TASKS].frozen <= FROZEN_W'(count_reg)))
        else $error("frozen count exceeds registered tasks");

    // The task count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("registered count beyond table size");

    // Feeding the watchdog and reporting a frozen task exclude each other.
    a_feed_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && feed_watchdog) |-> (frozen_count == '0))
        else $error("feed reported with frozen tasks");

endmodule
